// ===== hdl/sfha_pkg.sv =====
// Package for the segregated-fit heap allocator.
// Holds request and status codes, list geometry and the size-class function.
// No dependencies.
package sfha_pkg;

  localparam int unsigned Classes   = 10;
  localparam int unsigned HeadBytes = 32;
  localparam int unsigned HeadsEnd  = 320;
  localparam int unsigned SplitMin  = 32;
  localparam int unsigned MinBlock  = 32;
  localparam int unsigned TagBytes  = 8;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  // Size class of a block size in bytes.
  function automatic logic [3:0] class_of(input logic [31:0] s);
    logic [3:0] c;
    c = 4'd9;
    if (s <= 32'd16) c = 4'd0;
    else if (s <= 32'd32) c = 4'd1;
    else if (s <= 32'd64) c = 4'd2;
    else if (s <= 32'd128) c = 4'd3;
    else if (s <= 32'd256) c = 4'd4;
    else if (s <= 32'd512) c = 4'd5;
    else if (s <= 32'd1024) c = 4'd6;
    else if (s <= 32'd2048) c = 4'd7;
    else if (s <= 32'd4096) c = 4'd8;
    return c;
  endfunction

endpackage

// ===== hdl/sfha_store.sv =====
// Word store of the heap: one 32-bit slot per 8 bytes.
// One write and one registered read port. Depends on nothing.
module sfha_store #(
  parameter int unsigned DEPTH = 8192,
  parameter int unsigned AW    = 13
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  // Synchronous write and registered read.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/segregated_fit_heap_allocator_top.sv =====
// Top level of the segregated-fit heap allocator.
// Uses sfha_pkg and sfha_store.
//
// channel | direction | handshake          | payload
// req     | in        | req_valid/ready    | req_type, request_size, payload_address
// rsp     | out       | rsp_valid/ready    | granted_address, status
// cfg     | in        | cfg_we             | cfg_wdata (heap_limit)
//
// One transaction at a time. Every store read sets its address and then waits in S_RD
// for the registered read data. An allocate scans size classes and examines free-list
// nodes, then takes a block or grows the heap; a free merges free neighbors into the
// freed block. After reset a clearing pass writes the ten list heads; no request
// is taken meanwhile. A result waits in its output register while rsp_ready is low.
module segregated_fit_heap_allocator_top #(
  parameter int unsigned HEAP_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic        req_type,
  input  logic [15:0] request_size,
  input  logic [15:0] payload_address,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [15:0] granted_address,
  output logic [1:0]  status,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata
);

  localparam int unsigned Slots = HEAP_BYTES / 8;
  localparam int unsigned AW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned SW = $clog2(Slots + 1);

  typedef enum logic [18:0] {
    S_INIT   = 19'd1 << 0,  S_IDLE   = 19'd1 << 1,  S_FCHK   = 19'd1 << 2,
    S_FPREV  = 19'd1 << 3,  S_FNEXT  = 19'd1 << 4,  S_ANEXT  = 19'd1 << 5,
    S_AHDR   = 19'd1 << 6,  S_AGROW  = 19'd1 << 7,  S_UNLP   = 19'd1 << 8,
    S_UNLN   = 19'd1 << 9,  S_UNLW   = 19'd1 << 10, S_TAGS   = 19'd1 << 11,
    S_PUSHH  = 19'd1 << 12, S_PUSHW  = 19'd1 << 13, S_DONE   = 19'd1 << 14,
    S_RSP    = 19'd1 << 15, S_RD     = 19'd1 << 16, S_FNXS   = 19'd1 << 17,
    S_AHEAD  = 19'd1 << 18
  } state_t;

  state_t state, ret;
  logic        busy_wait;
  logic [2:0]  step;
  logic [6:0]  init_cnt;
  logic [16:0] heap_limit, heap_break;
  logic        rtype;
  logic [31:0] need, blk, bsz, hd, cur, tmp_p, tmp_n, nb;
  logic [3:0]  cls;
  logic [SW-1:0] steps;
  logic        split_pend, after_unlink_next;
  logic        we;
  logic [31:0] waddr_b, wdata, raddr_b, rdata;

  sfha_store #(.DEPTH(Slots), .AW(AW)) u_store (
    .clk(clk), .we(we), .waddr(waddr_b[AW+2:3]), .wdata(wdata),
    .raddr(raddr_b[AW+2:3]), .rdata(rdata)
  );

  assign req_ready = (state == S_IDLE);

  logic [31:0] lim;
  logic [31:0] sz_rnd;
  always_comb begin
    lim = ({15'd0, heap_limit} < 32'(HEAP_BYTES)) ? {15'd0, heap_limit} : 32'(HEAP_BYTES);
    sz_rnd = ({16'd0, request_size} + 32'd23) & ~32'd7;
  end

  // Sequencer; each read goes through S_RD, which waits for the registered read data.
  always_ff @(posedge clk) begin
    we <= 1'b0;
    if (rst) begin
      state <= S_INIT; init_cnt <= '0; rsp_valid <= 1'b0; heap_break <= 17'd320;
      heap_limit <= 17'd65536; step <= '0; busy_wait <= 1'b0;
    end else begin
      if (cfg_we) heap_limit <= cfg_wdata;
      unique case (state)
        S_INIT: begin
          // Heads: tag 33 at h and h+24, self links at h+8 and h+16.
          we <= 1'b1;
          waddr_b <= {22'd0, init_cnt[6:2], init_cnt[1:0], 3'd0};
          wdata <= (init_cnt[1:0] == 2'd0 || init_cnt[1:0] == 2'd3) ? 32'd33
                   : {22'd0, init_cnt[6:2], 2'd0, 3'd0} ;
          init_cnt <= init_cnt + 7'd1;
          if (init_cnt == 7'd39) state <= S_IDLE;
        end
        S_IDLE: if (req_valid) begin
          rtype <= req_type;
          if (req_type == sfha_pkg::REQ_ALLOC) begin
            need <= (sz_rnd < 32'd32) ? 32'd32 : sz_rnd;
            cls  <= sfha_pkg::class_of((sz_rnd < 32'd32) ? 32'd32 : sz_rnd);
            state <= S_AHEAD;
          end else begin
            blk <= {16'd0, payload_address} - 32'd8;
            if (payload_address[2:0] != 3'd0 || payload_address < 16'd328 ||
                ({16'd0, payload_address} - 32'd8) >= {15'd0, heap_break}) begin
              granted_address <= '0; status <= sfha_pkg::ST_IGNORED; state <= S_RSP;
            end else begin
              raddr_b <= {16'd0, payload_address} - 32'd8; ret <= S_FCHK; state <= S_RD;
            end
          end
        end
        S_RD: begin
          if (!busy_wait) busy_wait <= 1'b1;
          else begin busy_wait <= 1'b0; state <= ret; end
        end
        // Allocate: read head successor of class cls.
        S_AHEAD: begin
          if (cls == 4'd10) state <= S_AGROW;
          else begin
            hd <= 32'(cls) * 32'd32;
            raddr_b <= 32'(cls) * 32'd32 + 32'd8; ret <= S_ANEXT; state <= S_RD;
            steps <= '0;
          end
        end
        S_ANEXT: begin
          cur <= rdata;
          if (rdata == hd || steps == SW'(Slots)) begin
            cls <= cls + 4'd1; state <= S_AHEAD;
          end else begin
            raddr_b <= rdata; ret <= S_AHDR; state <= S_RD;
          end
        end
        S_AHDR: begin
          if (!rdata[0] && {rdata[31:1], 1'b0} >= need) begin
            blk <= cur; bsz <= {rdata[31:1], 1'b0};
            split_pend <= ({rdata[31:1], 1'b0} - need) > 32'(sfha_pkg::SplitMin);
            after_unlink_next <= 1'b0;
            raddr_b <= cur + 32'd16; ret <= S_UNLP; state <= S_RD;
          end else begin
            raddr_b <= cur + 32'd8; steps <= steps + SW'(1); ret <= S_ANEXT; state <= S_RD;
          end
        end
        S_AGROW: begin
          if ({15'd0, heap_break} > lim || need > lim - {15'd0, heap_break}) begin
            granted_address <= '0; status <= sfha_pkg::ST_NOSPACE; state <= S_RSP;
          end else begin
            blk <= {15'd0, heap_break}; bsz <= need;
            heap_break <= heap_break + need[16:0];
            split_pend <= 1'b0; step <= '0; state <= S_TAGS;
            granted_address <= 16'(heap_break + 17'd8);
          end
        end
        // Unlink cur: read pred then succ, then four writes.
        S_UNLP: begin
          tmp_p <= rdata; raddr_b <= cur + 32'd8; ret <= S_UNLN; state <= S_RD;
        end
        S_UNLN: begin tmp_n <= rdata; step <= '0; state <= S_UNLW; end
        S_UNLW: begin
          we <= 1'b1; step <= step + 3'd1;
          unique case (step)
            3'd0: begin waddr_b <= tmp_p + 32'd8;  wdata <= tmp_n; end
            3'd1: begin waddr_b <= tmp_n + 32'd16; wdata <= tmp_p; end
            3'd2: begin waddr_b <= cur + 32'd8;    wdata <= '0; end
            default: begin waddr_b <= cur + 32'd16; wdata <= '0; end
          endcase
          if (step == 3'd3) begin
            step <= '0;
            if (rtype == sfha_pkg::REQ_ALLOC) begin
              granted_address <= 16'(blk + 32'd8); state <= S_TAGS;
            end else if (!after_unlink_next) begin
              state <= S_FNXS;
            end else state <= S_TAGS;
          end
        end
        // Write header and footer; for a split allocate, the remainder's tags follow.
        S_TAGS: begin
          we <= 1'b1; step <= step + 3'd1;
          if (rtype == sfha_pkg::REQ_ALLOC) begin
            unique case (step)
              3'd0: begin waddr_b <= blk;
                wdata <= (split_pend ? need : bsz) | 32'd1; end
              3'd1: begin waddr_b <= blk + (split_pend ? need : bsz) - 32'd8;
                wdata <= (split_pend ? need : bsz) | 32'd1; end
              3'd2: begin waddr_b <= blk + need; wdata <= bsz - need; end
              default: begin waddr_b <= blk + bsz - 32'd8; wdata <= bsz - need; end
            endcase
            if (step == 3'd1 && !split_pend) begin
              status <= sfha_pkg::ST_DONE; state <= S_RSP;
            end
            if (step == 3'd3) begin
              cur <= blk + need; bsz <= bsz - need; state <= S_PUSHH;
            end
          end else begin
            if (step == 3'd0) begin waddr_b <= blk; wdata <= bsz; end
            else begin waddr_b <= blk + bsz - 32'd8; wdata <= bsz; end
            if (step == 3'd1) begin cur <= blk; state <= S_PUSHH; end
          end
        end
        // Push cur (size bsz) to the front of its class list.
        S_PUSHH: begin
          hd <= 32'(sfha_pkg::class_of(bsz)) * 32'd32;
          raddr_b <= 32'(sfha_pkg::class_of(bsz)) * 32'd32 + 32'd8;
          ret <= S_PUSHW; state <= S_RD; step <= '0;
        end
        S_PUSHW: begin
          we <= 1'b1; step <= step + 3'd1;
          if (step == 3'd0) tmp_n <= rdata;
          unique case (step)
            3'd0: begin waddr_b <= cur + 32'd16; wdata <= hd; end
            3'd1: begin waddr_b <= cur + 32'd8;  wdata <= tmp_n; end
            3'd2: begin waddr_b <= hd + 32'd8;   wdata <= cur; end
            default: begin waddr_b <= tmp_n + 32'd16; wdata <= cur; end
          endcase
          if (step == 3'd3) begin
            if (rtype == sfha_pkg::REQ_FREE) granted_address <= '0;
            status <= sfha_pkg::ST_DONE; state <= S_RSP;
          end
        end
        // Free: check the used bit, then look at the footer in front.
        S_FCHK: begin
          if (!rdata[0]) begin
            granted_address <= '0; status <= sfha_pkg::ST_IGNORED; state <= S_RSP;
          end else begin
            bsz <= {rdata[31:1], 1'b0}; raddr_b <= blk - 32'd8;
            ret <= S_FPREV; state <= S_RD;
          end
        end
        S_FPREV: begin
          if (!rdata[0]) begin
            blk <= blk - {rdata[31:1], 1'b0}; cur <= blk - {rdata[31:1], 1'b0};
            bsz <= bsz + {rdata[31:1], 1'b0}; after_unlink_next <= 1'b0;
            raddr_b <= blk - {rdata[31:1], 1'b0} + 32'd16; ret <= S_UNLP; state <= S_RD;
          end else state <= S_FNXS;
        end
        S_FNXS: begin
          nb <= blk + bsz;
          if (blk + bsz < {15'd0, heap_break}) begin
            raddr_b <= blk + bsz; ret <= S_FNEXT; state <= S_RD;
          end else begin step <= '0; state <= S_TAGS; end
        end
        S_FNEXT: begin
          if (!rdata[0]) begin
            cur <= nb; bsz <= bsz + {rdata[31:1], 1'b0}; after_unlink_next <= 1'b1;
            raddr_b <= nb + 32'd16; ret <= S_UNLP; state <= S_RD;
          end else begin step <= '0; state <= S_TAGS; end
        end
        S_RSP: begin
          rsp_valid <= 1'b1; state <= S_DONE;
        end
        S_DONE: if (rsp_valid && rsp_ready) begin
          rsp_valid <= 1'b0; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/sfha_checker.sv =====
// Port checker for the heap allocator top level, with its bind.
// Depends on sfha_pkg and segregated_fit_heap_allocator_top.
module sfha_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [15:0] granted_address,
  input logic [1:0]  status
);

  // No new request is taken while a result is pending.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready) else $error("request taken while result pending");

  // Once a request is taken the engine is busy in the next cycle.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready) else $error("request port stayed open");

  // A pending result holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(granted_address) && $stable(status))
    else $error("result changed while stalled");

  // Failures return address zero.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != sfha_pkg::ST_DONE |-> granted_address == 16'd0)
    else $error("failure with nonzero address");

  // Status codes are in range.
  a_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> status <= sfha_pkg::ST_IGNORED) else $error("bad status code");

endmodule

bind segregated_fit_heap_allocator_top sfha_checker u_chk (
  .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready),
  .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
  .granted_address(granted_address), .status(status)
);

// ===== test/segregated_fit_heap_allocator_top_test.sv =====
// Testbench for the segregated-fit heap allocator top level.
// Depends on sfha_pkg and segregated_fit_heap_allocator_top; takes each expected response
// from its heap image or a typed row, checking allocates and frees under random stalls.
`timescale 1ns / 100ps

module segregated_fit_heap_allocator_top_test;

  localparam int unsigned HeapSlots = 8192;
  // Long enough for a full walk of every class list in every transaction.
  localparam int unsigned CycleLimit = 1600000000;

  typedef struct {
    logic        kind;
    logic [15:0] size;
    logic [15:0] addr;
    bit          typed;
    logic [15:0] want_addr;
    logic [1:0]  want_status;
  } stim_row_t;

  typedef struct {
    logic [15:0] addr;
    logic [1:0]  status;
  } grant_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  logic        req_type = sfha_pkg::REQ_ALLOC;
  logic [15:0] request_size = '0;
  logic [15:0] payload_address = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  logic [15:0] granted_address;
  logic [1:0]  status;
  logic        cfg_we = 1'b0;
  logic [16:0] cfg_wdata = '0;

  segregated_fit_heap_allocator_top dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
    .request_size(request_size), .payload_address(payload_address),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
    .granted_address(granted_address), .status(status),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow heap image, with a mask of the slots that have been written.
  logic [31:0] heap_img [0:HeapSlots-1];
  bit          heap_set [0:HeapSlots-1];
  logic [31:0] save_img [0:HeapSlots-1];
  bit          save_set [0:HeapSlots-1];
  int unsigned heap_end;
  int unsigned heap_cap;
  bit          touched_unset;

  grant_t      pending_grants[$];
  int unsigned live_blocks[$];
  int unsigned freed_blocks[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned cycles = 0;

  function automatic int unsigned slot_rd(int unsigned a);
    int unsigned i;
    i = (a >> 3) % HeapSlots;
    if (!heap_set[i]) touched_unset = 1'b1;
    return heap_img[i];
  endfunction

  function automatic void slot_wr(int unsigned a, int unsigned v);
    int unsigned i;
    i = (a >> 3) % HeapSlots;
    heap_img[i] = v;
    heap_set[i] = 1'b1;
  endfunction

  function automatic void write_tags(int unsigned b, int unsigned sz, int unsigned used);
    slot_wr(b, sz | used);
    slot_wr(b + sz - sfha_pkg::TagBytes, sz | used);
  endfunction

  function automatic int unsigned size_class(int unsigned s);
    int unsigned top;
    int unsigned c;
    top = 32;
    c = 1;
    if (s <= 16) return 0;
    while (c < sfha_pkg::Classes - 1 && s > top) begin
      top = top << 1;
      c++;
    end
    return c;
  endfunction

  function automatic void list_unlink(int unsigned b);
    int unsigned p;
    int unsigned n;
    p = slot_rd(b + 16);
    n = slot_rd(b + 8);
    slot_wr(p + 8, n);
    slot_wr(n + 16, p);
    slot_wr(b + 8, 0);
    slot_wr(b + 16, 0);
  endfunction

  function automatic void list_push(int unsigned b);
    int unsigned h;
    int unsigned n;
    h = sfha_pkg::HeadBytes * size_class(slot_rd(b) & ~32'd1);
    n = slot_rd(h + 8);
    slot_wr(b + 16, h);
    slot_wr(b + 8, n);
    slot_wr(h + 8, b);
    slot_wr(n + 16, b);
  endfunction

  function automatic void heap_reset();
    for (int unsigned i = 0; i < HeapSlots; i++) heap_set[i] = 1'b0;
    for (int unsigned c = 0; c < sfha_pkg::Classes; c++) begin
      write_tags(sfha_pkg::HeadBytes * c, sfha_pkg::HeadBytes, 1);
      slot_wr(sfha_pkg::HeadBytes * c + 8, sfha_pkg::HeadBytes * c);
      slot_wr(sfha_pkg::HeadBytes * c + 16, sfha_pkg::HeadBytes * c);
    end
    heap_end = sfha_pkg::HeadsEnd;
    heap_cap = 65536;
  endfunction

  // First-fit search over the class lists, then growth of the heap end.
  function automatic grant_t predict_alloc(int unsigned size);
    grant_t      g;
    int unsigned want;
    int unsigned h;
    int unsigned b;
    int unsigned bs;
    int unsigned steps;
    int unsigned cap;
    want = (size + 2 * sfha_pkg::TagBytes + 7) & ~32'd7;
    if (want < sfha_pkg::MinBlock) want = sfha_pkg::MinBlock;
    for (int unsigned c = size_class(want); c < sfha_pkg::Classes; c++) begin
      h = sfha_pkg::HeadBytes * c;
      b = slot_rd(h + 8);
      steps = 0;
      while (b != h && steps < HeapSlots) begin
        bs = slot_rd(b) & ~32'd1;
        if ((slot_rd(b) & 32'd1) == 0 && bs >= want) begin
          list_unlink(b);
          if (bs - want > sfha_pkg::SplitMin) begin
            write_tags(b, want, 1);
            write_tags(b + want, bs - want, 0);
            list_push(b + want);
          end else begin
            write_tags(b, bs, 1);
          end
          g.addr = 16'(b + sfha_pkg::TagBytes);
          g.status = sfha_pkg::ST_DONE;
          return g;
        end
        b = slot_rd(b + 8);
        steps++;
      end
    end
    cap = (heap_cap < 65536) ? heap_cap : 65536;
    if (heap_end > cap || want > cap - heap_end) begin
      g.addr = '0;
      g.status = sfha_pkg::ST_NOSPACE;
      return g;
    end
    b = heap_end;
    heap_end += want;
    write_tags(b, want, 1);
    g.addr = 16'(b + sfha_pkg::TagBytes);
    g.status = sfha_pkg::ST_DONE;
    return g;
  endfunction

  // Free with merging of free neighbors in front and behind.
  function automatic grant_t predict_free(int unsigned pay);
    grant_t      g;
    int unsigned b;
    int unsigned bs;
    int unsigned fs;
    int unsigned nb;
    g.addr = '0;
    b = pay - sfha_pkg::TagBytes;
    if ((pay & 7) != 0 || pay < sfha_pkg::HeadsEnd + sfha_pkg::TagBytes ||
        b >= heap_end || (slot_rd(b) & 32'd1) == 0) begin
      g.status = sfha_pkg::ST_IGNORED;
      return g;
    end
    bs = slot_rd(b) & ~32'd1;
    if ((slot_rd(b - sfha_pkg::TagBytes) & 32'd1) == 0) begin
      fs = slot_rd(b - sfha_pkg::TagBytes) & ~32'd1;
      b -= fs;
      list_unlink(b);
      bs += fs;
    end
    nb = b + bs;
    if (nb < heap_end && (slot_rd(nb) & 32'd1) == 0) begin
      bs += slot_rd(nb) & ~32'd1;
      list_unlink(nb);
    end
    write_tags(b, bs, 0);
    list_push(b);
    g.status = sfha_pkg::ST_DONE;
    return g;
  endfunction

  // Commits the transaction to the shadow heap unless it would read a never-written slot.
  function automatic bit heap_commit(logic kind, int unsigned size, int unsigned pay,
                                     output grant_t g);
    int unsigned end_keep;
    save_img = heap_img;
    save_set = heap_set;
    end_keep = heap_end;
    touched_unset = 1'b0;
    g = (kind == sfha_pkg::REQ_ALLOC) ? predict_alloc(size) : predict_free(pay);
    if (touched_unset) begin
      heap_img = save_img;
      heap_set = save_set;
      heap_end = end_keep;
      return 1'b0;
    end
    if (g.status == sfha_pkg::ST_DONE && kind == sfha_pkg::REQ_ALLOC)
      live_blocks.push_back(g.addr);
    if (g.status == sfha_pkg::ST_DONE && kind == sfha_pkg::REQ_FREE)
      freed_blocks.push_back(pay);
    return 1'b1;
  endfunction

  // Drives one transaction after a random gap, none when calm, and holds it until accepted.
  task automatic offer(logic kind, logic [15:0] size, logic [15:0] pay, grant_t g,
                       bit calm);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_type <= kind;
    request_size <= size;
    payload_address <= pay;
    do @(posedge clk); while (!req_ready);
    pending_grants.push_back(g);
  endtask

  // Writes the heap limit once every response is back and the engine has settled.
  task automatic set_heap_cap(logic [16:0] v);
    req_valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    heap_cap = v;
  endtask

  // Random transaction: mostly allocates and frees of live blocks, some noise.
  task automatic random_phase(int unsigned count);
    grant_t      g;
    logic        kind;
    logic [15:0] size;
    logic [15:0] pay;
    int unsigned pick;
    int unsigned k;
    for (int unsigned n = 0; n < count; n++) begin
      do begin
        pick = $urandom_range(0, 99);
        kind = sfha_pkg::REQ_ALLOC;
        size = 16'($urandom_range(0, 200));
        pay = '0;
        if (pick < 8) size = 16'($urandom_range(200, 3000));
        else if (pick < 11) size = 16'($urandom);
        else if (pick < 48 && live_blocks.size() != 0) begin
          kind = sfha_pkg::REQ_FREE;
          k = $urandom_range(0, live_blocks.size() - 1);
          pay = 16'(live_blocks[k]);
          live_blocks.delete(k);
        end else if (pick < 52 && freed_blocks.size() != 0) begin
          kind = sfha_pkg::REQ_FREE;
          pay = 16'(freed_blocks[$urandom_range(0, freed_blocks.size() - 1)]);
        end else if (pick < 58) begin
          kind = sfha_pkg::REQ_FREE;
          pay = 16'($urandom);
        end
      end while (!heap_commit(kind, size, pay, g));
      offer(kind, size, pay, g, ((n / 48) % 4) == 0);
    end
  endtask

  // Response checker with its own stall counter and one long hold-off.
  int unsigned rsp_wait = 0;
  always @(posedge clk) begin
    grant_t want;
    bit     took;
    took = 1'b0;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        took = 1'b1;
        results_seen++;
        if (pending_grants.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected response: addr %0d status %0d", granted_address, status);
        end else begin
          want = pending_grants.pop_front();
          if (granted_address !== want.addr || status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("response mismatch: expected addr %0d status %0d, got addr %0d status %0d",
                       want.addr, want.status, granted_address, status);
          end
        end
      end
      if (took) begin
        if (results_seen == 150) rsp_wait = 600;
        else if (((results_seen / 64) % 3) == 0) rsp_wait = 0;
        else rsp_wait = $urandom_range(0, 17);
        rsp_ready <= (rsp_wait == 0);
      end else if (rsp_wait > 0) begin
        rsp_wait--;
        rsp_ready <= (rsp_wait == 0);
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // Run guard.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  stim_row_t rows [0:18];

  initial begin
    grant_t g;
    grant_t typed_g;

    // Directed rows: extremes, errors, split and both kinds of merge.
    rows[0]  = '{sfha_pkg::REQ_ALLOC, 16'd0,    16'd0,    1'b1, 16'd328, sfha_pkg::ST_DONE};
    rows[1]  = '{sfha_pkg::REQ_ALLOC, 16'hFFFF, 16'd0,    1'b1, 16'd0,   sfha_pkg::ST_NOSPACE};
    rows[2]  = '{sfha_pkg::REQ_FREE,  16'd0,    16'd0,    1'b1, 16'd0,   sfha_pkg::ST_IGNORED};
    rows[3]  = '{sfha_pkg::REQ_FREE,  16'd0,    16'd333,  1'b1, 16'd0,   sfha_pkg::ST_IGNORED};
    rows[4]  = '{sfha_pkg::REQ_FREE,  16'd0,    16'd320,  1'b1, 16'd0,   sfha_pkg::ST_IGNORED};
    rows[5]  = '{sfha_pkg::REQ_FREE,  16'd0,    16'hFFF8, 1'b1, 16'd0,   sfha_pkg::ST_IGNORED};
    rows[6]  = '{sfha_pkg::REQ_ALLOC, 16'd100,  16'd0,    1'b0, 16'd0,   sfha_pkg::ST_DONE};
    rows[7]  = '{sfha_pkg::REQ_ALLOC, 16'd100,  16'hFFFF, 1'b0, 16'd0,   sfha_pkg::ST_DONE};
    rows[8]  = '{sfha_pkg::REQ_ALLOC, 16'd100,  16'd0,    1'b0, 16'd0,   sfha_pkg::ST_DONE};
    rows[9]  = '{sfha_pkg::REQ_ALLOC, 16'd5000, 16'd0,    1'b0, 16'd0,   sfha_pkg::ST_DONE};
    rows[10] = '{sfha_pkg::REQ_FREE,  16'hFFFF, 16'd328,  1'b0, 16'd0,   sfha_pkg::ST_DONE};
    rows[11] = '{sfha_pkg::REQ_FREE,  16'd0,    16'd328,  1'b1, 16'd0,   sfha_pkg::ST_IGNORED};
    rows[12] = '{sfha_pkg::REQ_FREE,  16'd0,    16'd480,  1'b0, 16'd0,   sfha_pkg::ST_DONE};
    rows[13] = '{sfha_pkg::REQ_FREE,  16'd0,    16'd360,  1'b0, 16'd0,   sfha_pkg::ST_DONE};
    rows[14] = '{sfha_pkg::REQ_ALLOC, 16'd40,   16'd0,    1'b0, 16'd0,   sfha_pkg::ST_DONE};
    rows[15] = '{sfha_pkg::REQ_FREE,  16'd0,    16'd720,  1'b0, 16'd0,   sfha_pkg::ST_DONE};
    rows[16] = '{sfha_pkg::REQ_ALLOC, 16'hFFFF, 16'd0,    1'b1, 16'd0,   sfha_pkg::ST_NOSPACE};
    rows[17] = '{sfha_pkg::REQ_FREE,  16'd0,    16'hFFFF, 1'b1, 16'd0,   sfha_pkg::ST_IGNORED};
    rows[18] = '{sfha_pkg::REQ_ALLOC, 16'd16,   16'd0,    1'b0, 16'd0,   sfha_pkg::ST_DONE};

    heap_reset();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      if (!heap_commit(rows[i].kind, rows[i].size, rows[i].addr, g)) begin
        rows[i].kind = sfha_pkg::REQ_FREE;
        rows[i].addr = '0;
        void'(heap_commit(sfha_pkg::REQ_FREE, 0, 0, g));
      end
      if (rows[i].typed) begin
        typed_g.addr = rows[i].want_addr;
        typed_g.status = rows[i].want_status;
        g = typed_g;
      end
      offer(rows[i].kind, rows[i].size, rows[i].addr, g, i < 6);
    end

    // Random phases across low, middle and full heap limits.
    set_heap_cap(17'd1024);
    random_phase(100);
    set_heap_cap(17'd12000);
    random_phase(300);
    set_heap_cap(17'd65536);
    random_phase(400);
    req_valid <= 1'b0;

    while (pending_grants.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
